/* rtl/srf_pkg.sv */
`timescale 1ns / 1ps
// Shared types and constants of the section ring FIFO.
package srf_pkg;

  // Item kinds seen by the executor
  typedef enum logic {
    KIND_PUSH = 1'b0,
    KIND_POP  = 1'b1
  } kind_t;

  // Result status codes
  typedef enum logic [1:0] {
    STAT_OK    = 2'd0,
    STAT_EMPTY = 2'd1,
    STAT_FULL  = 2'd2
  } status_t;

  localparam int HELD_W = 13;
  localparam int CNT_W  = 14;
  localparam int LEN_W  = 13;

  localparam logic [CNT_W-1:0] COUNT_MAX = 14'd8191;
  localparam logic [LEN_W-1:0] LEN_BIAS  = 13'd3;

  // Classified input item
  typedef struct packed {
    kind_t      kind;
    logic [7:0] data;
  } cmd_t;

  // Result item
  typedef struct packed {
    logic [7:0]        out_byte;
    logic              last;
    logic [HELD_W-1:0] held;
    status_t           status;
  } res_t;

endpackage

/* rtl/srf_ram.sv */
`timescale 1ns / 1ps
// Generic single-write, single-read RAM with registered read data.
module srf_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16384
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

/* rtl/srf_queue.sv */
`timescale 1ns / 1ps
// Small register queue with push/full and pop/empty handshakes.
module srf_queue #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] wdata,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] rdata,
  output logic             empty
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [PW-1:0] LAST_SLOT = PW'(DEPTH - 1);
  localparam logic [CW-1:0] CNT_FULL  = CW'(DEPTH);

  logic [WIDTH-1:0] entries [DEPTH];
  logic [PW-1:0]    wp;
  logic [PW-1:0]    rp;
  logic [CW-1:0]    cnt;
  logic [CW-1:0]    cnt_next;
  logic             do_push;
  logic             do_pop;

  assign full    = (cnt == CNT_FULL);
  assign empty   = (cnt == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rdata   = entries[rp];

  // Track occupancy
  always_comb begin
    unique case ({do_push, do_pop})
      2'b10:   cnt_next = cnt + 1'b1;
      2'b01:   cnt_next = cnt - 1'b1;
      default: cnt_next = cnt;
    endcase
  end

  // Advance pointers and count
  always_ff @(posedge clk) begin
    if (rst) begin
      wp  <= '0;
      rp  <= '0;
      cnt <= '0;
    end else begin
      cnt <= cnt_next;
      if (do_push) begin
        wp <= (wp == LAST_SLOT) ? '0 : wp + 1'b1;
      end
      if (do_pop) begin
        rp <= (rp == LAST_SLOT) ? '0 : rp + 1'b1;
      end
    end
  end

  // Hold item payloads
  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wp] <= wdata;
    end
  end

endmodule

/* rtl/srf_front.sv */
`timescale 1ns / 1ps
// Front end: accepts items, classifies them and queues them for the executor.
module srf_front (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  output logic          full,
  input  logic          mode,
  input  logic [7:0]    data_byte,
  input  logic          cmd_pop,
  output srf_pkg::cmd_t cmd,
  output logic          cmd_empty
);

  localparam int CMD_W = $bits(srf_pkg::cmd_t);

  srf_pkg::cmd_t    cmd_in;
  logic [CMD_W-1:0] q_rdata;

  // Classify the incoming item
  always_comb begin
    cmd_in.kind = mode ? srf_pkg::KIND_POP : srf_pkg::KIND_PUSH;
    cmd_in.data = data_byte;
  end

  srf_queue #(
    .WIDTH(CMD_W),
    .DEPTH(2)
  ) u_cmd_q (
    .clk  (clk),
    .rst  (rst),
    .push (push),
    .wdata(cmd_in),
    .full (full),
    .pop  (cmd_pop),
    .rdata(q_rdata),
    .empty(cmd_empty)
  );

  assign cmd = srf_pkg::cmd_t'(q_rdata);

endmodule

/* rtl/srf_back.sv */
`timescale 1ns / 1ps
// Back end: executes push and pop items against the ring store.
module srf_back #(
  parameter int STORE_DEPTH = 16384
) (
  input  logic          clk,
  input  logic          rst,
  input  srf_pkg::cmd_t cmd,
  input  logic          cmd_empty,
  output logic          cmd_pop,
  output logic          res_push,
  output srf_pkg::res_t res,
  input  logic          res_full
);

  localparam int AW = $clog2(STORE_DEPTH);
  localparam int UW = $clog2(STORE_DEPTH + 1);
  localparam int LW = srf_pkg::LEN_W;
  localparam int CW = srf_pkg::CNT_W;
  localparam logic [AW-1:0] LAST_ADDR = AW'(STORE_DEPTH - 1);
  localparam logic [UW-1:0] DEPTH_U   = UW'(STORE_DEPTH);

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_READ = 2'b10
  } state_t;

  state_t        st, st_next;
  logic [AW-1:0] wr_ptr, wr_ptr_next;
  logic [AW-1:0] rd_ptr, rd_ptr_next;
  logic [AW-1:0] start_ptr, start_ptr_next;
  logic [UW-1:0] used, used_next;
  logic [CW-1:0] count, count_next;
  logic [LW-1:0] push_off, push_off_next;
  logic [LW-1:0] push_len, push_len_next;
  logic [LW-1:0] pop_off, pop_off_next;
  logic [LW-1:0] pop_len, pop_len_next;

  logic [AW-1:0] wr_ptr_inc;
  logic [AW-1:0] rd_ptr_inc;
  logic          tail_done;
  logic          full_hit;
  logic          sec_done;
  logic          pop_last;
  logic [LW-1:0] push_len_calc;
  logic [LW-1:0] pop_len_calc;
  logic [LW-1:0] pop_off_inc;
  logic          ram_we;
  logic          ram_re;
  logic [7:0]    ram_rdata;

  function automatic logic [AW-1:0] ring_next(input logic [AW-1:0] p);
    return (p == LAST_ADDR) ? '0 : p + 1'b1;
  endfunction

  assign wr_ptr_inc    = ring_next(wr_ptr);
  assign rd_ptr_inc    = ring_next(rd_ptr);
  assign tail_done     = (push_off >= LW'(2)) && (push_off + 1'b1 == push_len);
  assign full_hit      = (used >= DEPTH_U) || (tail_done && (count >= srf_pkg::COUNT_MAX));
  assign push_len_calc = (push_len | {{(LW-8){1'b0}}, cmd.data}) + srf_pkg::LEN_BIAS;
  assign pop_len_calc  = (pop_len | {{(LW-8){1'b0}}, ram_rdata}) + srf_pkg::LEN_BIAS;
  assign pop_off_inc   = pop_off + 1'b1;

  // Execute one item; a pop that reads the store goes through ST_READ to take the read data
  always_comb begin
    st_next        = st;
    wr_ptr_next    = wr_ptr;
    rd_ptr_next    = rd_ptr;
    start_ptr_next = start_ptr;
    used_next      = used;
    count_next     = count;
    push_off_next  = push_off;
    push_len_next  = push_len;
    pop_off_next   = pop_off;
    pop_len_next   = pop_len;
    cmd_pop        = 1'b0;
    res_push       = 1'b0;
    ram_we         = 1'b0;
    ram_re         = 1'b0;
    sec_done       = 1'b0;
    pop_last       = 1'b0;
    res.out_byte   = 8'h00;
    res.last       = 1'b0;
    res.status     = srf_pkg::STAT_OK;

    unique case (st)
      ST_IDLE: begin
        if (!cmd_empty && !res_full) begin
          cmd_pop = 1'b1;
          if (cmd.kind == srf_pkg::KIND_PUSH) begin
            res_push = 1'b1;
            if (full_hit) begin
              // Drop the byte and discard the partial section
              wr_ptr_next   = start_ptr;
              used_next     = (used >= UW'(push_off)) ? used - UW'(push_off) : '0;
              push_off_next = '0;
              push_len_next = '0;
              res.status    = srf_pkg::STAT_FULL;
            end else begin
              ram_we        = 1'b1;
              wr_ptr_next   = wr_ptr_inc;
              used_next     = used + 1'b1;
              push_off_next = push_off + 1'b1;
              sec_done      = tail_done;
              // Pick up the section length from header bytes 1 and 2
              if (push_off == LW'(1)) begin
                push_len_next = {{(LW-12){1'b0}}, cmd.data[3:0], 8'h00};
              end else if (push_off == LW'(2)) begin
                push_len_next = push_len_calc;
                sec_done      = tail_done || (push_len_calc == srf_pkg::LEN_BIAS);
              end
              if (sec_done) begin
                count_next     = count + 1'b1;
                start_ptr_next = wr_ptr_inc;
                push_off_next  = '0;
                push_len_next  = '0;
                res.last       = 1'b1;
              end
            end
          end else if (count == '0) begin
            res_push   = 1'b1;
            res.status = srf_pkg::STAT_EMPTY;
          end else begin
            // Issue the store read and retire the byte from the ring
            ram_re      = 1'b1;
            rd_ptr_next = rd_ptr_inc;
            used_next   = used - 1'b1;
            st_next     = ST_READ;
          end
        end
      end
      ST_READ: begin
        res_push     = 1'b1;
        res.out_byte = ram_rdata;
        pop_off_next = pop_off_inc;
        // Track the section length from the header bytes as they pass
        priority if (pop_off == LW'(1)) begin
          pop_len_next = {{(LW-12){1'b0}}, ram_rdata[3:0], 8'h00};
        end else if (pop_off == LW'(2)) begin
          pop_len_next = pop_len_calc;
          pop_last     = (pop_len_calc == srf_pkg::LEN_BIAS);
        end else if (pop_off >= LW'(3)) begin
          pop_last = (pop_off_inc >= pop_len);
        end else begin
          pop_last = 1'b0;
        end
        if (pop_last) begin
          count_next   = count - 1'b1;
          pop_off_next = '0;
          pop_len_next = '0;
          res.last     = 1'b1;
        end
        st_next = ST_IDLE;
      end
      default: begin
        st_next = ST_IDLE;
      end
    endcase

    res.held = count_next[srf_pkg::HELD_W-1:0];
  end

  // Update control state
  always_ff @(posedge clk) begin
    if (rst) begin
      st        <= ST_IDLE;
      wr_ptr    <= '0;
      rd_ptr    <= '0;
      start_ptr <= '0;
      used      <= '0;
      count     <= '0;
      push_off  <= '0;
      push_len  <= '0;
      pop_off   <= '0;
      pop_len   <= '0;
    end else begin
      st        <= st_next;
      wr_ptr    <= wr_ptr_next;
      rd_ptr    <= rd_ptr_next;
      start_ptr <= start_ptr_next;
      used      <= used_next;
      count     <= count_next;
      push_off  <= push_off_next;
      push_len  <= push_len_next;
      pop_off   <= pop_off_next;
      pop_len   <= pop_len_next;
    end
  end

  srf_ram #(
    .WIDTH(8),
    .DEPTH(STORE_DEPTH)
  ) u_store (
    .clk  (clk),
    .we   (ram_we),
    .waddr(wr_ptr),
    .wdata(cmd.data),
    .re   (ram_re),
    .raddr(rd_ptr),
    .rdata(ram_rdata)
  );

  // Section count stays within one past the saturation point
  a_count_range: assert property (@(posedge clk) disable iff (rst)
    count <= srf_pkg::COUNT_MAX + 1'b1)
    else $error("section count out of range");

  // Fill level never passes the store depth
  a_used_range: assert property (@(posedge clk) disable iff (rst)
    used <= DEPTH_U)
    else $error("store fill level out of range");

  // A store read only happens with a complete section held
  a_read_needs_section: assert property (@(posedge clk) disable iff (rst)
    ram_re |-> (count != '0) && (used != '0))
    else $error("store read with no complete section");

  // A read cycle always produces its result the next cycle
  a_read_completes: assert property (@(posedge clk) disable iff (rst)
    ram_re |=> (st == ST_READ) && res_push)
    else $error("pop read did not complete");

  // Results are only pushed into a result queue with room
  a_res_room: assert property (@(posedge clk) disable iff (rst)
    res_push |-> !res_full)
    else $error("result pushed into full queue");

endmodule

/* rtl/section_ring_fifo_unit.sv */
`timescale 1ns / 1ps
// A push or an empty pop puts its result into the result queue as it is accepted; a pop
// that reads a byte does so from ST_READ, after the registered ring store RAM read.
// Pushes, empty pops: one item per cycle while the result queue has room and no read waits.
// Input and result queues of two entries each let both sides stall on their own.
// Reset (rst, synchronous): clears pointers, fill level, section count and both queues;
// the store contents are not cleared and no clearing pass runs.
module section_ring_fifo_unit #(
  parameter int STORE_DEPTH = 16384
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        push,
  output logic        full,
  input  logic        mode,
  input  logic [7:0]  data_byte,
  output logic        empty,
  input  logic        pop,
  output logic [7:0]  out_byte,
  output logic        last_of_section,
  output logic [12:0] sections_held,
  output logic [1:0]  status
);

  localparam int RES_W = $bits(srf_pkg::res_t);

  srf_pkg::cmd_t    cmd;
  logic             cmd_empty;
  logic             cmd_pop;
  logic             res_push;
  srf_pkg::res_t    res_in;
  logic             res_full;
  logic [RES_W-1:0] res_q;
  srf_pkg::res_t    res_out;

  srf_front u_front (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .full     (full),
    .mode     (mode),
    .data_byte(data_byte),
    .cmd_pop  (cmd_pop),
    .cmd      (cmd),
    .cmd_empty(cmd_empty)
  );

  srf_back #(
    .STORE_DEPTH(STORE_DEPTH)
  ) u_back (
    .clk      (clk),
    .rst      (rst),
    .cmd      (cmd),
    .cmd_empty(cmd_empty),
    .cmd_pop  (cmd_pop),
    .res_push (res_push),
    .res      (res_in),
    .res_full (res_full)
  );

  srf_queue #(
    .WIDTH(RES_W),
    .DEPTH(2)
  ) u_res_q (
    .clk  (clk),
    .rst  (rst),
    .push (res_push),
    .wdata(res_in),
    .full (res_full),
    .pop  (pop),
    .rdata(res_q),
    .empty(empty)
  );

  // Unpack the oldest result onto the ports
  assign res_out         = srf_pkg::res_t'(res_q);
  assign out_byte        = res_out.out_byte;
  assign last_of_section = res_out.last;
  assign sections_held   = res_out.held;
  assign status          = res_out.status;

endmodule

/* sim/srf_result_checker.sv */
`timescale 1ns / 1ps
// Result checker for the section ring FIFO: mirrors the store and compares each popped result.
module srf_result_checker #(
  parameter int STORE_DEPTH = 16384
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        push,
  input  logic        full,
  input  logic        mode,
  input  logic [7:0]  data_byte,
  input  logic        empty,
  input  logic        pop,
  input  logic [7:0]  out_byte,
  input  logic        last_of_section,
  input  logic [12:0] sections_held,
  input  logic [1:0]  status,
  output int          mismatches,
  output int          outstanding
);

  localparam int PTR_W = $clog2(STORE_DEPTH);

  // Shadow copy of the store and its bookkeeping
  logic [7:0]                 section_bytes [STORE_DEPTH];
  logic [PTR_W-1:0]           wr_ptr;
  logic [PTR_W-1:0]           rd_ptr;
  logic [PTR_W-1:0]           sec_start;
  logic [PTR_W:0]             fill;
  logic [srf_pkg::HELD_W-1:0] held;
  logic [srf_pkg::LEN_W-1:0]  push_ofs;
  logic [srf_pkg::LEN_W-1:0]  push_len;
  logic [srf_pkg::LEN_W-1:0]  pop_ofs;
  logic [srf_pkg::LEN_W-1:0]  pop_len;
  srf_pkg::res_t              awaited_results [$];
  int                         bad_count;

  function automatic logic [PTR_W-1:0] ring_step(logic [PTR_W-1:0] p);
    return (p == PTR_W'(STORE_DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  // Apply one item to the shadow store and return the result it should produce
  function automatic srf_pkg::res_t apply_section_item(srf_pkg::kind_t kind,
                                                       logic [7:0] value);
    srf_pkg::res_t    r;
    logic             closes;
    logic [PTR_W-1:0] p1;
    logic [PTR_W-1:0] p2;
    r = '0;
    r.status = srf_pkg::STAT_OK;
    if (kind == srf_pkg::KIND_PUSH) begin
      closes = (push_ofs >= 2) && (push_ofs + 1 == push_len);
      if (fill >= STORE_DEPTH || (closes && held >= srf_pkg::COUNT_MAX)) begin
        // Drop the byte and discard the section being written
        wr_ptr = sec_start;
        fill = (fill >= push_ofs) ? fill - push_ofs : '0;
        push_ofs = '0;
        push_len = '0;
        r.status = srf_pkg::STAT_FULL;
      end else begin
        section_bytes[wr_ptr] = value;
        wr_ptr = ring_step(wr_ptr);
        fill = fill + 1'b1;
        // Pick up section_length from header bytes 1 and 2
        if (push_ofs == 1) begin
          push_len = {1'b0, value[3:0], 8'h00};
        end else if (push_ofs == 2) begin
          push_len = (push_len | {5'b0, value}) + srf_pkg::LEN_BIAS;
          if (push_len == srf_pkg::LEN_BIAS) closes = 1'b1;
        end
        push_ofs = push_ofs + 1'b1;
        if (closes) begin
          held = held + 1'b1;
          sec_start = wr_ptr;
          push_ofs = '0;
          push_len = '0;
          r.last = 1'b1;
        end
      end
    end else if (held == 0) begin
      r.status = srf_pkg::STAT_EMPTY;
    end else begin
      // Read the length of the oldest section on its first byte
      if (pop_ofs == 0) begin
        p1 = ring_step(rd_ptr);
        p2 = ring_step(p1);
        pop_len = {1'b0, section_bytes[p1][3:0], section_bytes[p2]} + srf_pkg::LEN_BIAS;
      end
      r.out_byte = section_bytes[rd_ptr];
      rd_ptr = ring_step(rd_ptr);
      if (fill > 0) fill = fill - 1'b1;
      pop_ofs = pop_ofs + 1'b1;
      if (pop_ofs >= pop_len) begin
        r.last = 1'b1;
        held = held - 1'b1;
        pop_ofs = '0;
        pop_len = '0;
      end
    end
    r.held = held;
    return r;
  endfunction

  function automatic void compare_field(string field, logic [15:0] want, logic [15:0] got);
    if (got !== want) begin
      $display("%0t ns: %s expected %0d, got %0d", $time, field, want, got);
      bad_count++;
    end
  endfunction

  always @(posedge clk) begin
    srf_pkg::res_t want;
    if (rst) begin
      wr_ptr = '0;
      rd_ptr = '0;
      sec_start = '0;
      fill = '0;
      held = '0;
      push_ofs = '0;
      push_len = '0;
      pop_ofs = '0;
      pop_len = '0;
      awaited_results.delete();
    end else begin
      // Check the result taken at this edge before queuing a new prediction
      if (pop && !empty) begin
        if (awaited_results.size() == 0) begin
          $display("%0t ns: unexpected result, out_byte %0d last %0d held %0d status %0d",
                   $time, out_byte, last_of_section, sections_held, status);
          bad_count++;
        end else begin
          want = awaited_results.pop_front();
          compare_field("out_byte", 16'(want.out_byte), 16'(out_byte));
          compare_field("last_of_section", 16'(want.last), 16'(last_of_section));
          compare_field("sections_held", 16'(want.held), 16'(sections_held));
          compare_field("status", 16'(want.status), 16'(status));
        end
      end
      if (push && !full) begin
        awaited_results.push_back(apply_section_item(srf_pkg::kind_t'(mode), data_byte));
      end
    end
    mismatches <= bad_count;
    outstanding <= awaited_results.size();
  end

endmodule

/* sim/testbench.sv */
`timescale 1ns / 1ps
// Top of the section ring FIFO testbench: clock, reset, item stimulus and verdict.
module testbench;

  localparam int STORE_DEPTH = 16384;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        push = 1'b0;
  logic        full;
  logic        mode = srf_pkg::KIND_PUSH;
  logic [7:0]  data_byte = 8'h00;
  logic        empty;
  logic        pop = 1'b0;
  logic [7:0]  out_byte;
  logic        last_of_section;
  logic [12:0] sections_held;
  logic [1:0]  status;
  int          mismatches;
  int          outstanding;

  int send_idle = 0;
  int take_idle = 0;
  int items_sent = 0;
  int hold_left = 0;
  bit hold_req = 1'b0;
  bit hold_done = 1'b0;

  section_ring_fifo_unit #(.STORE_DEPTH(STORE_DEPTH)) DUT (
    .clk, .rst, .push, .full, .mode, .data_byte,
    .empty, .pop, .out_byte, .last_of_section, .sections_held, .status
  );

  srf_result_checker #(.STORE_DEPTH(STORE_DEPTH)) result_check (
    .clk, .rst, .push, .full, .mode, .data_byte,
    .empty, .pop, .out_byte, .last_of_section, .sections_held, .status,
    .mismatches, .outstanding
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Take results; hold off once for a long stretch so the input side backs up
  always @(posedge clk) begin
    if (rst) begin
      pop <= 1'b0;
    end else if (hold_left > 0) begin
      pop <= 1'b0;
      hold_left <= hold_left - 1;
    end else if (hold_req && !hold_done) begin
      pop <= 1'b0;
      hold_left <= 80;
      hold_done <= 1'b1;
    end else begin
      pop <= ($urandom_range(99) >= take_idle);
    end
  end

  // Offer one item, idling first at random; return once it is accepted
  task automatic send_item(input srf_pkg::kind_t kind, input logic [7:0] value);
    int gap;
    gap = 0;
    while ($urandom_range(99) < send_idle) gap++;
    if (gap > 0) begin
      push <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    push <= 1'b1;
    mode <= kind;
    data_byte <= value;
    @(posedge clk);
    while (full) @(posedge clk);
    items_sent++;
  endtask

  // Push one well-formed section, now and then slipping a pop between its bytes
  task automatic send_section(input int body_len);
    logic [7:0] table_id;
    table_id = 8'($urandom_range(255));
    // Mostly a zero low nibble, so a misaligned stream does not declare huge sections
    if ($urandom_range(3) != 0) table_id[3:0] = 4'h0;
    send_item(srf_pkg::KIND_PUSH, table_id);
    send_item(srf_pkg::KIND_PUSH, {4'($urandom_range(15)), 4'(body_len >> 8)});
    send_item(srf_pkg::KIND_PUSH, 8'(body_len));
    repeat (body_len) begin
      if ($urandom_range(19) == 0) send_item(srf_pkg::KIND_POP, 8'($urandom));
      send_item(srf_pkg::KIND_PUSH, 8'($urandom));
    end
  endtask

  // Mix sections, pop bursts and stray items until enough items have gone in
  task automatic send_mixed(input int count);
    int stop_at;
    int pick;
    stop_at = items_sent + count;
    while (items_sent < stop_at) begin
      pick = $urandom_range(99);
      if (pick < 50) begin
        send_section(($urandom_range(29) == 0) ? $urandom_range(300) : $urandom_range(20));
      end else if (pick < 96) begin
        repeat ($urandom_range(1, 12)) send_item(srf_pkg::KIND_POP, 8'($urandom));
      end else begin
        send_item(srf_pkg::kind_t'($urandom_range(1)), 8'($urandom));
      end
    end
  endtask

  initial begin
    int guard;
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    send_idle = 7;
    take_idle = 84;
    // Pop with nothing held
    send_item(srf_pkg::KIND_POP, 8'hFF);
    // Shortest section: section_length zero, three header bytes only
    send_item(srf_pkg::KIND_PUSH, 8'h00);
    send_item(srf_pkg::KIND_PUSH, 8'hF0);
    send_item(srf_pkg::KIND_PUSH, 8'h00);
    // Start a section, then pop past the complete one: the partial bytes stay put
    send_item(srf_pkg::KIND_PUSH, 8'hFF);
    send_item(srf_pkg::KIND_PUSH, 8'h00);
    repeat (4) send_item(srf_pkg::KIND_POP, 8'h00);
    // Finish it with extreme payload bytes and drain it
    send_item(srf_pkg::KIND_PUSH, 8'h02);
    send_item(srf_pkg::KIND_PUSH, 8'hFF);
    send_item(srf_pkg::KIND_PUSH, 8'h00);
    repeat (6) send_item(srf_pkg::KIND_POP, 8'hA5);
    send_mixed(260);

    send_idle = 84;
    take_idle = 7;
    send_mixed(260);

    send_idle = 0;
    take_idle = 0;
    hold_req <= 1'b1;
    send_mixed(260);

    push <= 1'b0;
    @(posedge clk);
    guard = 0;
    while (outstanding != 0 && guard < 50000) begin
      @(posedge clk);
      guard++;
    end
    repeat (10) @(posedge clk);
    if (mismatches == 0 && outstanding == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  // Stop a hung run
  initial begin
    #10_000_000;
    $display("status: fail");
    $finish;
  end

endmodule
